/* sv/src_pkg.sv */
// Shared types, event codes, register indexes and constants for the stepper controller.
package src_pkg;

   typedef enum logic [2:0] {
      KIND_POWER_BUTTON = 3'd0,
      KIND_DIR_BUTTON   = 3'd1,
      KIND_COMMAND      = 3'd2,
      KIND_STEP_TICK    = 3'd3,
      KIND_CONTROL_PASS = 3'd4,
      KIND_REPORT_TICK  = 3'd5
   } kind_type;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_PERIOD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_SPAN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_INCREMENT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STOP_LIMIT = 3'd3;

   localparam logic [15:0] BASE_PERIOD_RESET     = 16'd15000;
   localparam logic [15:0] PERIOD_SPAN_RESET     = 16'd10000;
   localparam logic [15:0] RAMP_INCREMENT_RESET  = 16'd5000;
   localparam logic [15:0] RAMP_STOP_LIMIT_RESET = 16'd40000;

   localparam int RX_POWER_BIT = 7;
   localparam int RX_DIR_BIT   = 6;

   // cut = ceil(span * speed / 63): y = prod + 62, q = floor(y / 63)
   localparam int          PROD_W       = 22;
   localparam int          DIVIDEND_W   = 23;
   localparam logic [DIVIDEND_W-1:0] CEIL_BIAS = 23'd62;
   localparam logic [DIVIDEND_W-1:0] DIVISOR   = 23'd63;
   localparam logic [18:0] DIV63_RECIP  = 19'd266305;
   localparam int          DIV63_SHIFT  = 24;
   localparam int          RECIP_PROD_W = 42;

   // edges from a speed or span change until the cut register is current
   localparam logic [1:0]  CUT_LATENCY = 2'd3;

   typedef logic [6:0] percent_table_type [64];

   function automatic percent_table_type build_percent_table();
      percent_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 7'((100 * i) / 63);
      end
      return t;
   endfunction

   localparam percent_table_type PERCENT_TABLE = build_percent_table();

endpackage

/* sv/src_cut_calc.sv */
// Three-stage pipeline computing the period cut ceil(span * speed / 63).
module src_cut_calc (
   input  logic        clock,
   input  logic [15:0] span,
   input  logic [5:0]  speed,
   output logic [15:0] cut
);

   logic [src_pkg::PROD_W-1:0]       prod;
   logic [src_pkg::DIVIDEND_W-1:0]   dividend_ff;
   logic [src_pkg::DIVIDEND_W-1:0]   dividend_in;
   logic [src_pkg::RECIP_PROD_W-1:0] recip_ff;
   logic [src_pkg::RECIP_PROD_W-1:0] recip_in;
   logic [15:0]                      cut_ff;
   logic [15:0]                      cut_in;
   logic [src_pkg::DIVIDEND_W-1:0]   quot_est;
   logic [src_pkg::DIVIDEND_W-1:0]   remainder;

   assign prod        = src_pkg::PROD_W'(span) * src_pkg::PROD_W'(speed);
   assign dividend_in = src_pkg::DIVIDEND_W'(prod) + src_pkg::CEIL_BIAS;
   assign recip_in    = src_pkg::RECIP_PROD_W'(dividend_ff)
                        * src_pkg::RECIP_PROD_W'(src_pkg::DIV63_RECIP);

   // estimate is exact or one low; one compare fixes it
   always_comb begin
      quot_est  = src_pkg::DIVIDEND_W'(recip_ff >> src_pkg::DIV63_SHIFT);
      remainder = dividend_ff - ((quot_est << 6) - quot_est);
      cut_in    = (remainder >= src_pkg::DIVISOR) ? 16'(quot_est + 1'b1) : 16'(quot_est);
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      recip_ff    <= recip_in;
      cut_ff      <= cut_in;
   end

   assign cut = cut_ff;

endmodule

/* sv/stepper_reversing_controller.sv */
// Top level: wave-drive stepper controller with soft reversal and status reports.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_kind, req_rx_byte
//  rsp      out        rsp_valid / rsp_ready  coil, enable, period, running, dir, percent, tx
//  csr      in         csr_write_en           csr_index, csr_write_data
//
// One beat per cycle while req_ready is high; each beat's result is registered and
// shows in the next cycle. A control pass waits after a command beat or a span write
// while the cut multiplier/reciprocal pipeline settles; other beats pass unhindered.
// Reset is synchronous; after reset, control passes also wait for the cut pipeline.
// A held result stalls req only when the output register cannot drain.
module stepper_reversing_controller #(
   parameter int NUM_PHASES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_kind,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_coil_phases,
   output logic                            rsp_stepping_enabled,
   output logic [15:0]                     rsp_step_period,
   output logic                            rsp_motor_running,
   output logic                            rsp_counter_clockwise,
   output logic [6:0]                      rsp_speed_percent,
   output logic                            rsp_tx_valid,
   output logic [7:0]                      rsp_tx_byte,
   input  logic                            csr_write_en,
   input  logic [src_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_write_data
);

   localparam int PW = $clog2(NUM_PHASES + 1) + 1;
   localparam logic signed [PW-1:0] PHASE_FIRST = '0;
   localparam logic signed [PW-1:0] PHASE_LAST  = PW'(NUM_PHASES - 1);

   logic [15:0] base_ff, span_ff, ramp_ff, limit_ff;

   logic        running_ff, running_in;
   logic        rev_dir_ff, rev_dir_in;
   logic signed [PW-1:0] phase_ff, phase_in;
   logic [3:0]  coil_ff, coil_in;
   logic        tick_ff, tick_in;
   logic [15:0] period_ff, period_in;
   logic [5:0]  speed_ff, speed_in;
   logic [6:0]  percent_ff, percent_in;
   logic        lpr_ff, lpr_in, ldr_ff, ldr_in;
   logic        rpr_ff, rpr_in, rdr_ff, rdr_in;
   logic        rep_pwr_ff, rep_pwr_in, rep_dir_ff, rep_dir_in;
   logic        reversing_ff, reversing_in;
   logic        armed_ff, armed_in;
   logic        tx_valid_in;
   logic [7:0]  tx_byte_in;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_coil_ff;
   logic        rsp_tick_ff;
   logic [15:0] rsp_period_ff;
   logic        rsp_running_ff;
   logic        rsp_dir_ff;
   logic [6:0]  rsp_percent_ff;
   logic        rsp_tx_valid_ff;
   logic [7:0]  rsp_tx_byte_ff;

   logic [1:0]  busy_ff, busy_in;
   logic        cut_busy;
   logic [15:0] cut;
   logic [15:0] recompute_period;
   logic [16:0] ramp_sum;
   logic signed [PW-1:0] idx;
   logic        req_accept;
   logic        rsp_accept;

   src_cut_calc u_cut (
      .clock (clock),
      .span  (span_ff),
      .speed (speed_ff),
      .cut   (cut)
   );

   assign cut_busy   = (busy_ff != 2'd0);
   assign req_ready  = (!rsp_valid_ff || rsp_ready)
                       && !(cut_busy && req_kind == src_pkg::KIND_CONTROL_PASS);
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_ready;

   always_comb begin
      busy_in = busy_ff;
      if ((csr_write_en && csr_index == src_pkg::CSR_PERIOD_SPAN)
          || (req_accept && req_kind == src_pkg::KIND_COMMAND)) begin
         busy_in = src_pkg::CUT_LATENCY;
      end else if (cut_busy) begin
         busy_in = busy_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= src_pkg::BASE_PERIOD_RESET;
         span_ff  <= src_pkg::PERIOD_SPAN_RESET;
         ramp_ff  <= src_pkg::RAMP_INCREMENT_RESET;
         limit_ff <= src_pkg::RAMP_STOP_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            src_pkg::CSR_BASE_PERIOD:     base_ff  <= csr_write_data;
            src_pkg::CSR_PERIOD_SPAN:     span_ff  <= csr_write_data;
            src_pkg::CSR_RAMP_INCREMENT:  ramp_ff  <= csr_write_data;
            src_pkg::CSR_RAMP_STOP_LIMIT: limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      running_in   = running_ff;
      rev_dir_in   = rev_dir_ff;
      phase_in     = phase_ff;
      coil_in      = coil_ff;
      tick_in      = tick_ff;
      period_in    = period_ff;
      speed_in     = speed_ff;
      percent_in   = percent_ff;
      lpr_in       = lpr_ff;
      ldr_in       = ldr_ff;
      rpr_in       = rpr_ff;
      rdr_in       = rdr_ff;
      rep_pwr_in   = rep_pwr_ff;
      rep_dir_in   = rep_dir_ff;
      reversing_in = reversing_ff;
      armed_in     = armed_ff;
      tx_valid_in  = 1'b0;
      tx_byte_in   = 8'd0;
      ramp_sum     = 17'd0;
      idx          = phase_ff;
      recompute_period = (cut > base_ff) ? 16'd0 : (base_ff - cut);

      unique case (src_pkg::kind_type'(req_kind))
         src_pkg::KIND_POWER_BUTTON: begin
            lpr_in     = 1'b1;
            rep_pwr_in = 1'b1;
         end
         src_pkg::KIND_DIR_BUTTON: begin
            ldr_in     = 1'b1;
            rep_dir_in = 1'b1;
         end
         src_pkg::KIND_COMMAND: begin
            rpr_in   = req_rx_byte[src_pkg::RX_POWER_BIT];
            rdr_in   = req_rx_byte[src_pkg::RX_DIR_BIT];
            speed_in = req_rx_byte[5:0];
         end
         src_pkg::KIND_STEP_TICK: begin
            if (running_ff && tick_ff) begin
               if (idx < PHASE_FIRST || idx > PHASE_LAST) begin
                  idx = rev_dir_ff ? PHASE_LAST : PHASE_FIRST;
               end
               for (int b = 0; b < 4; b++) begin
                  coil_in[b] = (idx == PW'(b));
               end
               phase_in = rev_dir_ff ? (idx - PW'(1)) : (idx + PW'(1));
            end
         end
         src_pkg::KIND_CONTROL_PASS: begin
            if (!ldr_ff && !reversing_ff) begin
               period_in  = recompute_period;
               percent_in = src_pkg::PERCENT_TABLE[speed_ff];
            end
            if (lpr_ff || rpr_ff) begin
               running_in = !running_ff;
               lpr_in     = 1'b0;
               ldr_in     = 1'b0;
               rpr_in     = 1'b0;
               rdr_in     = 1'b0;
               tick_in    = !running_ff;
               coil_in    = 4'd0;
               phase_in   = rev_dir_ff ? PHASE_LAST : PHASE_FIRST;
            end
            if (ldr_in || rdr_in || reversing_ff) begin
               if (!running_in) begin
                  rev_dir_in = !rev_dir_ff;
                  ldr_in     = 1'b0;
                  rdr_in     = 1'b0;
               end else begin
                  ramp_sum     = {1'b0, period_in} + {1'b0, ramp_ff};
                  reversing_in = 1'b1;
                  period_in    = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
                  if (ramp_sum > {1'b0, limit_ff}) begin
                     running_in   = 1'b0;
                     ldr_in       = 1'b0;
                     rdr_in       = 1'b0;
                     rev_dir_in   = !rev_dir_ff;
                     lpr_in       = 1'b1;
                     reversing_in = 1'b0;
                  end
               end
            end
            armed_in = 1'b1;
         end
         src_pkg::KIND_REPORT_TICK: begin
            if (armed_ff) begin
               tx_valid_in = 1'b1;
               tx_byte_in  = {rep_pwr_ff, rep_dir_ff, 6'd0};
               rep_pwr_in  = 1'b0;
               rep_dir_in  = 1'b0;
               armed_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         rev_dir_ff   <= 1'b0;
         phase_ff     <= '0;
         coil_ff      <= 4'd0;
         tick_ff      <= 1'b0;
         period_ff    <= 16'd0;
         speed_ff     <= 6'd0;
         percent_ff   <= 7'd0;
         lpr_ff       <= 1'b0;
         ldr_ff       <= 1'b0;
         rpr_ff       <= 1'b0;
         rdr_ff       <= 1'b0;
         rep_pwr_ff   <= 1'b0;
         rep_dir_ff   <= 1'b0;
         reversing_ff <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= src_pkg::CUT_LATENCY;
      end else begin
         busy_ff <= busy_in;
         if (req_accept) begin
            running_ff   <= running_in;
            rev_dir_ff   <= rev_dir_in;
            phase_ff     <= phase_in;
            coil_ff      <= coil_in;
            tick_ff      <= tick_in;
            period_ff    <= period_in;
            speed_ff     <= speed_in;
            percent_ff   <= percent_in;
            lpr_ff       <= lpr_in;
            ldr_ff       <= ldr_in;
            rpr_ff       <= rpr_in;
            rdr_ff       <= rdr_in;
            rep_pwr_ff   <= rep_pwr_in;
            rep_dir_ff   <= rep_dir_in;
            reversing_ff <= reversing_in;
            armed_ff     <= armed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_coil_ff     <= coil_in;
         rsp_tick_ff     <= tick_in;
         rsp_period_ff   <= period_in;
         rsp_running_ff  <= running_in;
         rsp_dir_ff      <= rev_dir_in;
         rsp_percent_ff  <= percent_in;
         rsp_tx_valid_ff <= tx_valid_in;
         rsp_tx_byte_ff  <= tx_byte_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_coil_phases       = rsp_coil_ff;
   assign rsp_stepping_enabled  = rsp_tick_ff;
   assign rsp_step_period       = rsp_period_ff;
   assign rsp_motor_running     = rsp_running_ff;
   assign rsp_counter_clockwise = rsp_dir_ff;
   assign rsp_speed_percent     = rsp_percent_ff;
   assign rsp_tx_valid          = rsp_tx_valid_ff;
   assign rsp_tx_byte           = rsp_tx_byte_ff;

   a_coil_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(coil_ff))
      else $error("coil pattern has more than one bit set");

   a_tx_byte_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tx_valid_ff) |-> (rsp_tx_byte_ff == 8'd0))
      else $error("status byte set without a report beat");

   a_cut_settled: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == src_pkg::KIND_CONTROL_PASS) |-> !cut_busy)
      else $error("control pass taken before cut settled");

   a_report_disarms: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == src_pkg::KIND_REPORT_TICK) |=> !armed_ff)
      else $error("report still armed after report beat");

   a_cmd_starts_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == src_pkg::KIND_COMMAND) |=> (busy_ff == src_pkg::CUT_LATENCY))
      else $error("command beat did not restart cut settle count");

endmodule
